// File: rtl/core/gcmsbt_pkg.sv
// gcmsbt_pkg: sizes, op codes, state type and port structs for the mark-sweep block table
// no dependencies; used by gcmsbt_fill_table and gc_mark_sweep_block_table_unit

package gcmsbt_pkg;

   localparam int ADDR_BITS = 48;
   localparam int BUCKETS   = 64;   // power of two, bucket is the low hash bits
   localparam int WAYS      = 8;    // power of two, slot index is {bucket, way}

   localparam int BKT_W     = $clog2(BUCKETS);
   localparam int WAY_W     = $clog2(WAYS);
   localparam int FILL_W    = $clog2(WAYS + 1);
   localparam int IDX_W     = BKT_W + WAY_W;
   localparam int ENTRY_W   = ADDR_BITS + 1;
   localparam int SHIFT_W   = 6;
   localparam int FREED_W   = 10;
   localparam int REQ_DATA_W = ((ADDR_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((3 + FREED_W + 7) / 8) * 8;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(20);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_MARK   = 2'd1,
      OP_QUERY  = 2'd2,
      OP_SWEEP  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_LOAD,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              en;
      logic [BKT_W-1:0]  addr;
   } fill_rd_type;

   typedef struct packed {
      logic              en;
      logic [BKT_W-1:0]  addr;
      logic [FILL_W-1:0] data;
   } fill_wr_type;

endpackage

// File: rtl/core/gcmsbt_fill_table.sv
// gcmsbt_fill_table: per-bucket fill count memory with registered read
// per-entry valid bits cleared by reset make unwritten buckets read as zero; uses gcmsbt_pkg

module gcmsbt_fill_table (
   input  logic                          clock,
   input  logic                          reset,
   input  gcmsbt_pkg::fill_rd_type       fill_rd,
   input  gcmsbt_pkg::fill_wr_type       fill_wr,
   output logic [gcmsbt_pkg::FILL_W-1:0] fill_rd_data
);

   logic [gcmsbt_pkg::FILL_W-1:0] fill_mem [gcmsbt_pkg::BUCKETS];
   logic [gcmsbt_pkg::BUCKETS-1:0] vld_ff;
   logic [gcmsbt_pkg::FILL_W-1:0] rd_data_ff;
   logic                          rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (fill_wr.en) begin
         vld_ff[fill_wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_wr.en) begin
         fill_mem[fill_wr.addr] <= fill_wr.data;
      end
      if (fill_rd.en) begin
         rd_data_ff <= fill_mem[fill_rd.addr];
         rd_vld_ff  <= vld_ff[fill_rd.addr];
      end
   end

   assign fill_rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// File: rtl/core/gc_mark_sweep_block_table_unit.sv
// insert goes FILL, LOAD, RESP; mark and query go FILL, LOAD, SCAN, RESP, with one
// entry-memory read per filled slot of the addressed bucket up to the slot after the first hit;
// sweep runs FILL, LOAD, SCAN for each bucket in turn from bucket zero, then RESP
// throughput: one item at a time; the next item is taken while the previous result waits in rsp
// reset: synchronous, clears control, fill counts (valid bits), mark reference and arena_shift (20)
// entry memory holds no reset; only slots below their bucket's fill are ever read

module gc_mark_sweep_block_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gcmsbt_pkg::REQ_DATA_W-1:0] req_tdata,   // [47:0] object_addr
   input  logic [1:0]                        req_tuser,   // [1:0] op
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gcmsbt_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [0] found, [1] mark_result,
                                                          // [2] overflow, [12:3] freed_count
   // csr write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gcmsbt_pkg::SHIFT_W-1:0]    csr_wdata    // [5:0] arena_shift
);

   // fsm and request context
   gcmsbt_pkg::state_type                state_ff, state_in;
   gcmsbt_pkg::op_type                   op_ff, op_in;
   logic [gcmsbt_pkg::ADDR_BITS-1:0]     addr_ff, addr_in;
   logic [gcmsbt_pkg::BKT_W-1:0]         bucket_ff, bucket_in;
   logic [gcmsbt_pkg::SHIFT_W-1:0]       shift_ff;
   logic                                 mark_ref_ff, mark_ref_in;

   // scan pipeline: issue counter, one pending read, survivor count
   logic [gcmsbt_pkg::FILL_W-1:0]        fill_ff, fill_in;
   logic [gcmsbt_pkg::FILL_W-1:0]        issue_k_ff, issue_k_in;
   logic                                 pend_ff, pend_in;
   logic [gcmsbt_pkg::WAY_W-1:0]         pend_k_ff, pend_k_in;
   logic [gcmsbt_pkg::FILL_W-1:0]        keep_ff, keep_in;

   // result being built and result register
   logic                                 found_ff, found_in;
   logic                                 mres_ff, mres_in;
   logic                                 ovf_ff, ovf_in;
   logic [gcmsbt_pkg::FREED_W-1:0]       freed_ff, freed_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [gcmsbt_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   // entry memory: {flag, address} per slot
   logic [gcmsbt_pkg::ENTRY_W-1:0]       ent_mem [gcmsbt_pkg::BUCKETS * gcmsbt_pkg::WAYS];
   logic [gcmsbt_pkg::ENTRY_W-1:0]       ent_rd_ff;
   logic                                 ent_rd_en;
   logic [gcmsbt_pkg::IDX_W-1:0]         ent_rd_idx;
   logic                                 ent_wr_en;
   logic [gcmsbt_pkg::IDX_W-1:0]         ent_wr_idx;
   logic [gcmsbt_pkg::ENTRY_W-1:0]       ent_wr_data;

   // fill table ports
   gcmsbt_pkg::fill_rd_type              fill_rd;
   gcmsbt_pkg::fill_wr_type              fill_wr;
   logic [gcmsbt_pkg::FILL_W-1:0]        fill_rd_data;

   // helpers
   logic                                 req_fire;
   logic [gcmsbt_pkg::ADDR_BITS-1:0]     hash_shifted;
   logic                                 issue;
   logic                                 ent_flag;
   logic                                 hit;
   logic                                 scan_done;
   logic                                 rsp_free;

   assign req_fire     = req_tvalid && req_tready;
   assign req_tready   = (state_ff == gcmsbt_pkg::ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_free     = !rsp_valid_ff || rsp_tready;

   // bucket hash: shift then keep the low bits (shifts past the width give bucket 0)
   assign hash_shifted = req_tdata[gcmsbt_pkg::ADDR_BITS-1:0] >> shift_ff;

   // scan pipeline terms
   assign issue     = (state_ff == gcmsbt_pkg::ST_SCAN) && (issue_k_ff < fill_ff);
   assign ent_flag  = ent_rd_ff[gcmsbt_pkg::ENTRY_W-1];
   assign hit       = pend_ff && (ent_rd_ff[gcmsbt_pkg::ADDR_BITS-1:0] == addr_ff);
   assign scan_done = !issue && !pend_ff;

   gcmsbt_fill_table u_fill (
      .clock        (clock),
      .reset        (reset),
      .fill_rd      (fill_rd),
      .fill_wr      (fill_wr),
      .fill_rd_data (fill_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gcmsbt_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = gcmsbt_pkg::ST_FILL;
            end
         end
         gcmsbt_pkg::ST_FILL: begin
            state_in = gcmsbt_pkg::ST_LOAD;
         end
         gcmsbt_pkg::ST_LOAD: begin
            if (op_ff == gcmsbt_pkg::OP_INSERT) begin
               state_in = gcmsbt_pkg::ST_RESP;
            end else begin
               state_in = gcmsbt_pkg::ST_SCAN;
            end
         end
         gcmsbt_pkg::ST_SCAN: begin
            if (op_ff == gcmsbt_pkg::OP_SWEEP) begin
               if (scan_done) begin
                  if (bucket_ff == gcmsbt_pkg::BKT_W'(gcmsbt_pkg::BUCKETS - 1)) begin
                     state_in = gcmsbt_pkg::ST_RESP;
                  end else begin
                     state_in = gcmsbt_pkg::ST_FILL;
                  end
               end
            end else if (hit || scan_done) begin
               state_in = gcmsbt_pkg::ST_RESP;
            end
         end
         gcmsbt_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = gcmsbt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gcmsbt_pkg::ST_IDLE;
         end
      endcase
   end

   // memory controls and datapath next values
   always_comb begin
      op_in        = op_ff;
      addr_in      = addr_ff;
      bucket_in    = bucket_ff;
      mark_ref_in  = mark_ref_ff;
      fill_in      = fill_ff;
      issue_k_in   = issue_k_ff;
      pend_in      = 1'b0;
      pend_k_in    = pend_k_ff;
      keep_in      = keep_ff;
      found_in     = found_ff;
      mres_in      = mres_ff;
      ovf_in       = ovf_ff;
      freed_in     = freed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      fill_rd      = '{en: 1'b0, addr: bucket_ff};
      fill_wr      = '{en: 1'b0, addr: bucket_ff, data: keep_ff};
      ent_rd_en    = issue;
      ent_rd_idx   = {bucket_ff, issue_k_ff[gcmsbt_pkg::WAY_W-1:0]};
      ent_wr_en    = 1'b0;
      ent_wr_idx   = {bucket_ff, pend_k_ff};
      ent_wr_data  = ent_rd_ff;

      unique case (state_ff)
         gcmsbt_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in    = gcmsbt_pkg::op_type'(req_tuser);
               addr_in  = req_tdata[gcmsbt_pkg::ADDR_BITS-1:0];
               // sweep walks from bucket zero
               if (gcmsbt_pkg::op_type'(req_tuser) == gcmsbt_pkg::OP_SWEEP) begin
                  bucket_in = '0;
               end else begin
                  bucket_in = hash_shifted[gcmsbt_pkg::BKT_W-1:0];
               end
               found_in = 1'b0;
               mres_in  = 1'b0;
               ovf_in   = 1'b0;
               freed_in = '0;
            end
         end
         gcmsbt_pkg::ST_FILL: begin
            fill_rd.en = 1'b1;
         end
         gcmsbt_pkg::ST_LOAD: begin
            fill_in    = fill_rd_data;
            issue_k_in = '0;
            keep_in    = '0;
            if (op_ff == gcmsbt_pkg::OP_INSERT) begin
               if (fill_rd_data >= gcmsbt_pkg::FILL_W'(gcmsbt_pkg::WAYS)) begin
                  ovf_in = 1'b1;
               end else begin
                  // new entry starts unmarked
                  ent_wr_en    = 1'b1;
                  ent_wr_idx   = {bucket_ff, fill_rd_data[gcmsbt_pkg::WAY_W-1:0]};
                  ent_wr_data  = {!mark_ref_ff, addr_ff};
                  fill_wr.en   = 1'b1;
                  fill_wr.data = fill_rd_data + gcmsbt_pkg::FILL_W'(1);
               end
            end
         end
         gcmsbt_pkg::ST_SCAN: begin
            pend_in   = issue;
            pend_k_in = issue_k_ff[gcmsbt_pkg::WAY_W-1:0];
            if (issue) begin
               issue_k_in = issue_k_ff + gcmsbt_pkg::FILL_W'(1);
            end
            if (op_ff == gcmsbt_pkg::OP_SWEEP) begin
               // compact survivors toward the bucket start
               if (pend_ff) begin
                  if (ent_flag == mark_ref_ff) begin
                     ent_wr_en  = 1'b1;
                     ent_wr_idx = {bucket_ff, keep_ff[gcmsbt_pkg::WAY_W-1:0]};
                     keep_in    = keep_ff + gcmsbt_pkg::FILL_W'(1);
                  end else begin
                     freed_in = freed_ff + gcmsbt_pkg::FREED_W'(1);
                  end
               end
               if (scan_done) begin
                  fill_wr.en = 1'b1;
                  bucket_in  = bucket_ff + gcmsbt_pkg::BKT_W'(1);
                  if (bucket_ff == gcmsbt_pkg::BKT_W'(gcmsbt_pkg::BUCKETS - 1)) begin
                     mark_ref_in = !mark_ref_ff;
                  end
               end
            end else if (hit) begin
               found_in = 1'b1;
               if (op_ff == gcmsbt_pkg::OP_MARK) begin
                  mres_in = (ent_flag != mark_ref_ff);
                  if (ent_flag != mark_ref_ff) begin
                     ent_wr_en   = 1'b1;
                     ent_wr_data = {mark_ref_ff, addr_ff};
                  end
               end else begin
                  mres_in = (ent_flag == mark_ref_ff);
               end
            end
         end
         gcmsbt_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = gcmsbt_pkg::RSP_DATA_W'({freed_ff, ovf_ff, mres_ff, found_ff});
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcmsbt_pkg::ST_IDLE;
         mark_ref_ff  <= 1'b0;
         shift_ff     <= gcmsbt_pkg::SHIFT_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mark_ref_ff  <= mark_ref_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            shift_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      bucket_ff   <= bucket_in;
      fill_ff     <= fill_in;
      issue_k_ff  <= issue_k_in;
      pend_k_ff   <= pend_k_in;
      keep_ff     <= keep_in;
      found_ff    <= found_in;
      mres_ff     <= mres_in;
      ovf_ff      <= ovf_in;
      freed_ff    <= freed_in;
      rsp_data_ff <= rsp_data_in;
   end

   // entry memory, read-old on same-cycle access (writes never hit the slot being read)
   always_ff @(posedge clock) begin
      if (ent_wr_en) begin
         ent_mem[ent_wr_idx] <= ent_wr_data;
      end
      if (ent_rd_en) begin
         ent_rd_ff <= ent_mem[ent_rd_idx];
      end
   end

   // fill counts never exceed the bucket size
   assert property (@(posedge clock) disable iff (reset)
      fill_wr.en |-> (fill_wr.data <= gcmsbt_pkg::FILL_W'(gcmsbt_pkg::WAYS)))
      else $error("fill count above bucket size");

   // sweep compaction never writes ahead of the read pointer
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == gcmsbt_pkg::ST_SCAN) |-> (keep_ff <= issue_k_ff))
      else $error("survivor index ahead of scan");

   // mark reference only flips at the end of a sweep
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (mark_ref_ff != $past(mark_ref_ff))) |->
         ($past(op_ff) == gcmsbt_pkg::OP_SWEEP))
      else $error("mark reference flipped outside sweep");

   // entry writes happen only while loading an insert or scanning
   assert property (@(posedge clock) disable iff (reset)
      ent_wr_en |-> ((state_ff == gcmsbt_pkg::ST_SCAN) ||
                     ((state_ff == gcmsbt_pkg::ST_LOAD) && (op_ff == gcmsbt_pkg::OP_INSERT))))
      else $error("entry write outside insert or scan");

endmodule

// File: sim/tb.sv
// tb: self-checking bench for gc_mark_sweep_block_table_unit, directed table then random traffic
// depends on gcmsbt_pkg and the unit; a predictor of the table state checks the random responses

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT  = 20000;   // cycles with no handshake at all
   localparam int ITEMS_PER_PHASE = 100;
   localparam int PHASES          = 6;
   localparam int HOLD_CYCLES     = 400;     // long receiver hold-off to back up the unit
   localparam int POOL_DEPTH      = 40;

   typedef struct packed {
      logic                           found;
      logic                           mark_result;
      logic                           overflow;
      logic [gcmsbt_pkg::FREED_W-1:0] freed_count;
   } table_result_type;

   typedef struct {
      gcmsbt_pkg::op_type                op;
      logic [gcmsbt_pkg::ADDR_BITS-1:0]  addr;
      table_result_type                  want;
   } directed_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [gcmsbt_pkg::REQ_DATA_W-1:0]  req_tdata = '0;     // [47:0] object_addr
   logic [1:0]                         req_tuser = '0;     // [1:0] op
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [gcmsbt_pkg::RSP_DATA_W-1:0]  rsp_tdata;          // [0] found, [1] mark_result,
                                                           // [2] overflow, [12:3] freed_count
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [gcmsbt_pkg::SHIFT_W-1:0]     csr_wdata = '0;     // [5:0] arena_shift

   gc_mark_sweep_block_table_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // predicted table contents, kept in the order items are accepted
   logic [gcmsbt_pkg::ADDR_BITS-1:0] table_addr [gcmsbt_pkg::BUCKETS*gcmsbt_pkg::WAYS];
   logic                             table_flag [gcmsbt_pkg::BUCKETS*gcmsbt_pkg::WAYS];
   int                               table_fill [gcmsbt_pkg::BUCKETS];
   logic                             table_ref   = 1'b0;
   logic [gcmsbt_pkg::SHIFT_W-1:0]   table_shift = gcmsbt_pkg::SHIFT_RESET;

   table_result_type                 pending_results [$];
   directed_row_type                 directed_rows [$];
   logic [gcmsbt_pkg::ADDR_BITS-1:0] known_addrs [$];     // addresses likely to be in the table

   int  error_count     = 0;
   int  results_checked = 0;
   int  items_sent      = 0;
   int  sweeps_sent     = 0;
   int  overflows_seen  = 0;
   int  idle_cycles     = 0;
   bit  steady_tx       = 1'b0;

   initial begin
      foreach (table_fill[b]) table_fill[b] = 0;
   end

   // apply one op to the predicted table and return the response it should give
   function automatic table_result_type apply_table_op(gcmsbt_pkg::op_type op,
                                                       logic [gcmsbt_pkg::ADDR_BITS-1:0] addr);
      table_result_type                 res;
      logic [gcmsbt_pkg::ADDR_BITS-1:0] hashed;
      int                               bkt;
      int                               hit;
      int                               keep;
      int                               freed;
      int                               src;
      res    = '0;
      hashed = addr >> table_shift;    // any shift at or past the width lands in bucket 0
      bkt    = int'(hashed[gcmsbt_pkg::BKT_W-1:0]);
      hit    = -1;
      case (op)
         gcmsbt_pkg::OP_INSERT: begin
            if (table_fill[bkt] >= gcmsbt_pkg::WAYS) begin
               res.overflow = 1'b1;
            end else begin
               // new entries start out unmarked relative to the current reference
               table_addr[bkt*gcmsbt_pkg::WAYS + table_fill[bkt]] = addr;
               table_flag[bkt*gcmsbt_pkg::WAYS + table_fill[bkt]] = ~table_ref;
               table_fill[bkt]++;
            end
         end
         gcmsbt_pkg::OP_MARK, gcmsbt_pkg::OP_QUERY: begin
            // only the first matching entry counts, duplicates behind it are shadowed
            for (int k = 0; k < table_fill[bkt]; k++) begin
               if (hit < 0 && table_addr[bkt*gcmsbt_pkg::WAYS + k] == addr)
                  hit = bkt*gcmsbt_pkg::WAYS + k;
            end
            if (hit >= 0) begin
               res.found = 1'b1;
               if (op == gcmsbt_pkg::OP_QUERY) begin
                  res.mark_result = (table_flag[hit] == table_ref);
               end else if (table_flag[hit] != table_ref) begin
                  table_flag[hit] = table_ref;
                  res.mark_result = 1'b1;
               end
            end
         end
         default: begin
            // sweep: compact survivors to the front of each bucket, count the rest
            freed = 0;
            for (int b = 0; b < gcmsbt_pkg::BUCKETS; b++) begin
               keep = 0;
               for (int k = 0; k < table_fill[b]; k++) begin
                  src = b*gcmsbt_pkg::WAYS + k;
                  if (table_flag[src] == table_ref) begin
                     table_addr[b*gcmsbt_pkg::WAYS + keep] = table_addr[src];
                     table_flag[b*gcmsbt_pkg::WAYS + keep] = table_flag[src];
                     keep++;
                  end else begin
                     freed++;
                  end
               end
               table_fill[b] = keep;
            end
            res.freed_count = gcmsbt_pkg::FREED_W'(freed);
            table_ref = ~table_ref;
         end
      endcase
      return res;
   endfunction

   function automatic void add_row(gcmsbt_pkg::op_type op,
                                   logic [gcmsbt_pkg::ADDR_BITS-1:0] addr,
                                   bit found, bit marked, bit ovf, int freed);
      directed_row_type row;
      row.op   = op;
      row.addr = addr;
      row.want = '{found: found, mark_result: marked, overflow: ovf,
                   freed_count: gcmsbt_pkg::FREED_W'(freed)};
      directed_rows.push_back(row);
   endfunction

   // mostly short gaps, some long, none at all during steady stretches
   function automatic int pick_gap();
      int r;
      if (steady_tx) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // random address, usually steered into one of a few buckets so they fill and overflow
   function automatic logic [gcmsbt_pkg::ADDR_BITS-1:0] fresh_addr();
      logic [63:0]                      raw;
      logic [gcmsbt_pkg::ADDR_BITS-1:0] a;
      logic [gcmsbt_pkg::ADDR_BITS-1:0] field;
      raw = {$urandom, $urandom};
      a   = raw[gcmsbt_pkg::ADDR_BITS-1:0];
      if ($urandom_range(0, 9) < 7) begin
         field = gcmsbt_pkg::ADDR_BITS'(gcmsbt_pkg::BUCKETS - 1) << table_shift;
         a = (a & ~field) |
             ((gcmsbt_pkg::ADDR_BITS'($urandom_range(0, 7)) << table_shift) & field);
      end
      return a;
   endfunction

   // offer one item, wait for the handshake, then record what it should return
   task automatic send_item(input gcmsbt_pkg::op_type op,
                            input logic [gcmsbt_pkg::ADDR_BITS-1:0] addr,
                            input bit typed, input table_result_type want);
      int               gap;
      table_result_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      req_tuser  <= op;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      predicted = apply_table_op(op, addr);
      pending_results.push_back(typed ? want : predicted);
      items_sent++;
      if (op == gcmsbt_pkg::OP_SWEEP) sweeps_sent++;
      if (predicted.overflow) overflows_seen++;
   endtask

   // shift changes only with the unit drained
   task automatic write_shift(input logic [gcmsbt_pkg::SHIFT_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid   <= 1'b0;
      table_shift = value;
   endtask

   // response checker
   always @(posedge clock) begin
      table_result_type got;
      table_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{found: rsp_tdata[0], mark_result: rsp_tdata[1], overflow: rsp_tdata[2],
                 freed_count: rsp_tdata[12:3]};
         if (pending_results.size() == 0) begin
            $error("response with nothing outstanding: %p", got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, got.found);
               error_count++;
            end
            if (got.mark_result !== want.mark_result) begin
               $error("mark_result: expected %0d, got %0d", want.mark_result, got.mark_result);
               error_count++;
            end
            if (got.overflow !== want.overflow) begin
               $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
               error_count++;
            end
            if (got.freed_count !== want.freed_count) begin
               $error("freed_count: expected %0d, got %0d", want.freed_count, got.freed_count);
               error_count++;
            end
         end
         results_checked++;
      end
   end

   // receiver: random stalls, steady stretches, and one long hold-off
   initial begin
      int  stall_left;
      int  rx_cycle;
      int  r;
      bit  hold_done;
      stall_left = 0;
      rx_cycle   = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_checked >= 150) begin
            // sender keeps offering while this runs, so the unit backs up
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if ((rx_cycle / 200) % 4 == 1) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_tready <= 1'b1;
            end else if (r < 95) begin
               stall_left = $urandom_range(0, 2);
               rsp_tready <= 1'b0;
            end else begin
               stall_left = $urandom_range(20, 60);
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   // watchdog: no handshake of any kind for too long ends the run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("gc_mark_sweep_block_table_unit regression: fail");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [gcmsbt_pkg::SHIFT_W-1:0]   phase_shift [PHASES];
      logic [gcmsbt_pkg::ADDR_BITS-1:0] addr;
      gcmsbt_pkg::op_type               op;
      int                               r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset shift of 20; all-ones address lives in bucket 63,
      // zero and k << 26 all land in bucket 0
      add_row(gcmsbt_pkg::OP_QUERY,  48'h0,              0, 0, 0, 0);   // empty table
      add_row(gcmsbt_pkg::OP_MARK,   48'h0,              0, 0, 0, 0);   // absent address
      add_row(gcmsbt_pkg::OP_SWEEP,  48'h0,              0, 0, 0, 0);   // empty sweep
      add_row(gcmsbt_pkg::OP_INSERT, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0);
      add_row(gcmsbt_pkg::OP_QUERY,  48'hFFFF_FFFF_FFFF, 1, 0, 0, 0);   // not yet marked
      add_row(gcmsbt_pkg::OP_MARK,   48'hFFFF_FFFF_FFFF, 1, 1, 0, 0);
      add_row(gcmsbt_pkg::OP_MARK,   48'hFFFF_FFFF_FFFF, 1, 0, 0, 0);   // already marked
      add_row(gcmsbt_pkg::OP_QUERY,  48'hFFFF_FFFF_FFFF, 1, 1, 0, 0);
      add_row(gcmsbt_pkg::OP_INSERT, 48'h0,              0, 0, 0, 0);
      add_row(gcmsbt_pkg::OP_INSERT, 48'h0,              0, 0, 0, 0);   // duplicate entry
      for (int k = 1; k <= 6; k++)
         add_row(gcmsbt_pkg::OP_INSERT, gcmsbt_pkg::ADDR_BITS'(k) << 26, 0, 0, 0, 0);
      add_row(gcmsbt_pkg::OP_INSERT, gcmsbt_pkg::ADDR_BITS'(7) << 26,
              0, 0, 1, 0);                                              // bucket 0 full
      add_row(gcmsbt_pkg::OP_MARK,   48'h0,              1, 1, 0, 0);   // first duplicate
      add_row(gcmsbt_pkg::OP_QUERY,  48'h0,              1, 1, 0, 0);
      add_row(gcmsbt_pkg::OP_SWEEP,  48'h0,              0, 0, 0, 7);   // second zero, six more
      add_row(gcmsbt_pkg::OP_QUERY,  48'hFFFF_FFFF_FFFF, 1, 0, 0, 0);   // unmarked after flip
      add_row(gcmsbt_pkg::OP_QUERY,  gcmsbt_pkg::ADDR_BITS'(1) << 26,
              0, 0, 0, 0);                                              // swept away
      add_row(gcmsbt_pkg::OP_MARK,   48'h0,              1, 1, 0, 0);
      add_row(gcmsbt_pkg::OP_SWEEP,  48'hFFFF_FFFF_FFFF, 0, 0, 0, 1);
      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].addr, 1'b1, directed_rows[i].want);

      // random phases, each under its own shift: both extremes, past the address width,
      // back to reset value, then random settings
      phase_shift[0] = '0;
      phase_shift[1] = gcmsbt_pkg::SHIFT_W'(47);
      phase_shift[2] = '1;
      phase_shift[3] = gcmsbt_pkg::SHIFT_RESET;
      phase_shift[4] = gcmsbt_pkg::SHIFT_W'($urandom_range(0, 63));
      phase_shift[5] = gcmsbt_pkg::SHIFT_W'($urandom_range(1, 46));
      for (int p = 0; p < PHASES; p++) begin
         write_shift(phase_shift[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            steady_tx = ((n / 25) % 4 == 3);
            r = $urandom_range(0, 99);
            if (r < 35) begin
               op = gcmsbt_pkg::OP_INSERT;
               if (known_addrs.size() > 0 && $urandom_range(0, 3) == 0) begin
                  addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
               end else begin
                  addr = fresh_addr();
                  known_addrs.push_back(addr);
                  if (known_addrs.size() > POOL_DEPTH) void'(known_addrs.pop_front());
               end
            end else if (r < 93) begin
               op = (r < 65) ? gcmsbt_pkg::OP_MARK : gcmsbt_pkg::OP_QUERY;
               if (known_addrs.size() > 0 && $urandom_range(0, 6) != 0)
                  addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
               else
                  addr = fresh_addr();
            end else begin
               op   = gcmsbt_pkg::OP_SWEEP;
               addr = fresh_addr();   // ignored by the unit
            end
            send_item(op, addr, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("ran %0d items incl. %0d sweeps and %0d bucket overflows, over %0d shift settings",
               items_sent, sweeps_sent, overflows_seen, PHASES + 1);
      $display("checked %0d responses, %0d mismatches", results_checked, error_count);
      if (error_count == 0)
         $display("gc_mark_sweep_block_table_unit regression: pass");
      else
         $display("gc_mark_sweep_block_table_unit regression: fail");
      $finish;
   end

endmodule
